>>> src/gift_wrapping_convex_hull_unit_assert.svh
// Assertion macros for the convex hull unit.
`ifndef GIFT_WRAPPING_CONVEX_HULL_UNIT_ASSERT_SVH
`define GIFT_WRAPPING_CONVEX_HULL_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define GWCH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define GWCH_NEVER(lbl, clk, rst, expr, msg) \
   `GWCH_ASSERT(lbl, clk, rst, !(expr), msg)

`else

`define GWCH_ASSERT(lbl, clk, rst, prop, msg)

`define GWCH_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

>>> src/gwch_pkg.sv
// Shared types and constants of the convex hull unit.
package gwch_pkg;

   localparam int HULL_INDEX_WIDTH = 6;

   typedef enum logic {
      OP_AXBY,
      OP_AYBX
   } cross_op_type;

endpackage

>>> src/gwch_point_mem.sv
// Point store: one write port, one registered read port.
module gwch_point_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 48
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data_ff
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> src/gwch_cross_unit.sv
// Shared subtract and multiply unit: one cross product term per cycle.
module gwch_cross_unit #(
   parameter int CW = 24
) (
   input  logic                          clock,
   input  gwch_pkg::cross_op_type        op,
   input  logic signed [CW-1:0]          p_x,
   input  logic signed [CW-1:0]          p_y,
   input  logic signed [CW-1:0]          q_x,
   input  logic signed [CW-1:0]          q_y,
   input  logic signed [CW-1:0]          i_x,
   input  logic signed [CW-1:0]          i_y,
   output logic signed [2*CW+1:0]        prod_ff
);

   import gwch_pkg::*;

   localparam int PW = 2 * CW + 2;

   logic signed [CW:0]   a;
   logic signed [CW:0]   b;
   logic signed [PW-1:0] prod_in;

   always_comb begin
      unique case (op)
         OP_AXBY: begin
            a = (CW+1)'(p_x) - (CW+1)'(i_x);
            b = (CW+1)'(q_y) - (CW+1)'(i_y);
         end
         OP_AYBX: begin
            a = (CW+1)'(p_y) - (CW+1)'(i_y);
            b = (CW+1)'(q_x) - (CW+1)'(i_x);
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
      prod_in = PW'(a) * PW'(b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> src/gift_wrapping_convex_hull_unit.sv
// Gift-wrapping convex hull unit: top level with load and walk sequencer.
// Points load one per cycle while req_ready is high; the transfer with
// req_final_point set closes the set of n stored points (up to MAX_POINTS,
// extra points are dropped and reported on rsp_overflowed). The block then
// finds the start point and walks the hull, scanning all n points for
// each vertex and holding it on rsp until taken. The run time is set by
// the single read port of the point store and the one shared multiplier,
// which forms the two cross product terms for one point over consecutive
// cycles. req_ready is low for the whole run and returns after the
// transfer of the vertex with rsp_last_vertex set.
`include "gift_wrapping_convex_hull_unit_assert.svh"

module gift_wrapping_convex_hull_unit #(
   parameter int MAX_POINTS  = 64,
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_WIDTH-1:0]          req_px,
   input  logic signed [COORD_WIDTH-1:0]          req_py,
   input  logic                                   req_final_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [COORD_WIDTH-1:0]          rsp_hull_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_hull_y,
   output logic [gwch_pkg::HULL_INDEX_WIDTH-1:0]  rsp_hull_index,
   output logic                                   rsp_overflowed,
   output logic                                   rsp_last_vertex
);

   import gwch_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int IW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int DW   = 2 * CW;
   localparam int PW   = 2 * CW + 2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SR_RD,
      ST_SR_CHK,
      ST_Q_RD,
      ST_Q_LD,
      ST_I_RD,
      ST_MUL1,
      ST_MUL2,
      ST_CMP,
      ST_OUT
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNTW-1:0]   n_ff, n_in;
   logic              ovf_run_ff, ovf_run_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [CNTW-1:0]   emit_cnt_ff, emit_cnt_in;

   // payload
   logic [IW-1:0]          start_ff, start_in;
   logic signed [CW-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic [IW-1:0]          p_ff, p_in;
   logic signed [CW-1:0]   px_ff, px_in, py_ff, py_in;
   logic [IW-1:0]          q_ff, q_in;
   logic signed [CW-1:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic signed [CW-1:0]   ix_ff, ix_in, iy_ff, iy_in;
   logic signed [PW-1:0]   p1_ff, p1_in;
   logic                   last_ff, last_in;

   // datapath
   logic                   req_xfer;
   logic                   mem_we;
   logic [DW-1:0]          mem_wdata;
   logic [IW-1:0]          rd_addr;
   logic [DW-1:0]          rd_data;
   logic signed [CW-1:0]   rd_x, rd_y;
   logic [IW-1:0]          p_next;
   logic                   i_last;
   logic                   better;
   logic                   neg;
   cross_op_type           op;
   logic signed [CW-1:0]   op_ix, op_iy;
   logic signed [PW-1:0]   prod;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_xfer  = req_valid && req_ready;

   assign mem_we    = req_xfer && (count_ff < CNTW'(MAX_POINTS));
   assign mem_wdata = {req_px, req_py};
   assign rd_x      = rd_data[DW-1:CW];
   assign rd_y      = rd_data[CW-1:0];

   assign p_next = ((CNTW'(p_ff) + CNTW'(1)) == n_ff) ? '0 : p_ff + IW'(1);
   assign i_last = (CNTW'(i_ff) + CNTW'(1)) == n_ff;
   assign better = (i_ff == '0) || (rd_x < sx_ff) || ((rd_x == sx_ff) && (rd_y < sy_ff));
   assign neg    = p1_ff < prod;

   always_comb begin
      unique case (state_ff)
         ST_Q_RD: rd_addr = p_next;
         default: rd_addr = i_ff;
      endcase
   end

   always_comb begin
      if (state_ff == ST_MUL1) begin
         op    = OP_AXBY;
         op_ix = rd_x;
         op_iy = rd_y;
      end else begin
         op    = OP_AYBX;
         op_ix = ix_ff;
         op_iy = iy_ff;
      end
   end

   gwch_point_mem #(
      .DEPTH (MAX_POINTS),
      .AW    (IW),
      .DW    (DW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (count_ff[IW-1:0]),
      .wr_data    (mem_wdata),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   gwch_cross_unit #(
      .CW (CW)
   ) u_cross (
      .clock   (clock),
      .op      (op),
      .p_x     (px_ff),
      .p_y     (py_ff),
      .q_x     (qx_ff),
      .q_y     (qy_ff),
      .i_x     (op_ix),
      .i_y     (op_iy),
      .prod_ff (prod)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      n_in        = n_ff;
      ovf_run_in  = ovf_run_ff;
      i_in        = i_ff;
      emit_cnt_in = emit_cnt_ff;
      start_in    = start_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      p_in        = p_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      q_in        = q_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      ix_in       = ix_ff;
      iy_in       = iy_ff;
      p1_in       = p1_ff;
      last_in     = last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (mem_we) begin
                  count_in = count_ff + CNTW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_final_point) begin
                  n_in       = mem_we ? count_ff + CNTW'(1) : count_ff;
                  ovf_run_in = ovf_ff || !mem_we;
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  i_in       = '0;
                  state_in   = ST_SR_RD;
               end
            end
         end
         ST_SR_RD: begin
            state_in = ST_SR_CHK;
         end
         ST_SR_CHK: begin
            if (better) begin
               start_in = i_ff;
               sx_in    = rd_x;
               sy_in    = rd_y;
            end
            if (i_last) begin
               p_in        = better ? i_ff : start_ff;
               px_in       = better ? rd_x : sx_ff;
               py_in       = better ? rd_y : sy_ff;
               emit_cnt_in = '0;
               state_in    = ST_Q_RD;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_SR_RD;
            end
         end
         ST_Q_RD: begin
            q_in     = p_next;
            state_in = ST_Q_LD;
         end
         ST_Q_LD: begin
            qx_in    = rd_x;
            qy_in    = rd_y;
            i_in     = '0;
            state_in = ST_I_RD;
         end
         ST_I_RD: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            ix_in    = rd_x;
            iy_in    = rd_y;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p1_in    = prod;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (neg) begin
               q_in  = i_ff;
               qx_in = ix_ff;
               qy_in = iy_ff;
            end
            if (i_last) begin
               last_in  = ((neg ? i_ff : q_ff) == start_ff) ||
                          ((emit_cnt_ff + CNTW'(1)) >= n_ff);
               state_in = ST_OUT;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_I_RD;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               p_in        = q_ff;
               px_in       = qx_ff;
               py_in       = qy_ff;
               emit_cnt_in = emit_cnt_ff + CNTW'(1);
               state_in    = last_ff ? ST_LOAD : ST_Q_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         n_ff        <= '0;
         ovf_run_ff  <= 1'b0;
         i_ff        <= '0;
         emit_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         n_ff        <= n_in;
         ovf_run_ff  <= ovf_run_in;
         i_ff        <= i_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      p_ff     <= p_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      q_ff     <= q_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      ix_ff    <= ix_in;
      iy_ff    <= iy_in;
      p1_ff    <= p1_in;
      last_ff  <= last_in;
   end

   assign rsp_hull_x      = qx_ff;
   assign rsp_hull_y      = qy_ff;
   assign rsp_hull_index  = HULL_INDEX_WIDTH'(q_ff);
   assign rsp_overflowed  = ovf_run_ff;
   assign rsp_last_vertex = last_ff;

   `GWCH_NEVER(a_ready_vs_valid, clock, reset, req_ready && rsp_valid, "ready during run")
   `GWCH_ASSERT(a_count_bound, clock, reset, count_ff <= CNTW'(MAX_POINTS), "count overrun")
   `GWCH_ASSERT(a_emit_bound, clock, reset, rsp_valid |-> (emit_cnt_ff < n_ff), "too many vertices")
   `GWCH_ASSERT(a_last_returns, clock, reset, (rsp_valid && rsp_ready && rsp_last_vertex) |=> req_ready, "no return to load")
   `GWCH_ASSERT(a_scan_bound, clock, reset, ((state_ff == ST_MUL1) || (state_ff == ST_CMP)) |-> (CNTW'(i_ff) < n_ff), "scan index out of set")

endmodule
